// ----- design/dupm_pkg.sv -----
// Shared types and constants for the duplicate read marker.
// Holds the read record, the group marking codes and the flush control struct.
// Used by every module of the block but dupm_ram; depends on nothing.
`default_nettype none

package dupm_pkg;

    localparam int DUPM_GROUP_DEPTH = 32;
    localparam int DUPM_TAG_W       = 32;
    localparam int DUPM_POS_W       = 32;
    localparam int DUPM_SCORE_W     = 32;
    localparam int DUPM_ORI_W       = 2;
    localparam int DUPM_RAM_W       = DUPM_TAG_W + 1;

    typedef enum logic [1:0] {
        MARK_NONE         = 2'd0,
        MARK_ALL_BUT_BEST = 2'd1,
        MARK_UNPAIRED     = 2'd2
    } mark_mode_t;

    typedef struct packed {
        logic [DUPM_TAG_W-1:0]          tag;
        logic signed [DUPM_POS_W-1:0]   end_first;
        logic signed [DUPM_POS_W-1:0]   end_second;
        logic [DUPM_ORI_W-1:0]          orientation;
        logic                           is_secondary;
        logic                           is_paired;
        logic signed [DUPM_SCORE_W-1:0] score;
        logic                           last_read;
    } read_t;

    typedef struct packed {
        logic       start;
        mark_mode_t mode;
        logic       split;
        logic       last;
    } flush_ctrl_t;

endpackage

`default_nettype wire

// ----- design/duplicate_read_marker.sv -----
// Duplicate read marker. Reads arrive sorted by duplicate key; adjacent reads
// with equal keys are buffered as a group in a GROUP_DEPTH-entry RAM and, when
// the group closes, replayed in arrival order with a duplicate mark per read.
// A read that continues the open group is written to the buffer when taken; one
// that closes a group waits while the group is replayed, each result going via
// the buffer RAM's registered read and the single output register, and is then
// written. A read with last set triggers a further replay of its own group.
// fragment_mode selects pair or fragment marking; the user must write it only
// while the block is idle, which the block does not enforce. No clearing pass
// follows reset. Depends on dupm_pkg, dupm_ram, dupm_group and dupm_emit.
`default_nettype none

module duplicate_read_marker #(
    parameter int GROUP_DEPTH = dupm_pkg::DUPM_GROUP_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // read_tag[31:0], end_first[63:32], end_second[95:64], orientation[97:96],
    // score[129:98], zero fill[135:130]
    input  wire logic [135:0] s_tdata,
    // is_secondary[0], is_paired[1]
    input  wire logic [1:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_tag[31:0]
    output logic [31:0]       m_tdata,
    // duplicate[0], group_split[1]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import dupm_pkg::*;

    localparam int CNT_W = $clog2(GROUP_DEPTH + 1);
    localparam int IDX_W = $clog2(GROUP_DEPTH);

    read_t                 s_read;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DUPM_RAM_W-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DUPM_RAM_W-1:0] ram_rdata;
    flush_ctrl_t           flush_ctrl;
    logic [CNT_W-1:0]      flush_count;
    logic [IDX_W-1:0]      flush_best;
    logic                  flush_done;
    logic                  emit_busy;

    always_comb begin
        s_read.tag          = s_tdata[31:0];
        s_read.end_first    = s_tdata[63:32];
        s_read.end_second   = s_tdata[95:64];
        s_read.orientation  = s_tdata[97:96];
        s_read.score        = s_tdata[129:98];
        s_read.is_secondary = s_tuser[0];
        s_read.is_paired    = s_tuser[1];
        s_read.last_read    = s_tlast;
    end

    dupm_group #(
        .GROUP_DEPTH(GROUP_DEPTH),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_group (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_read     (s_read),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .flush_ctrl (flush_ctrl),
        .flush_count(flush_count),
        .flush_best (flush_best),
        .flush_done (flush_done)
    );

    dupm_ram #(
        .WIDTH(DUPM_RAM_W),
        .DEPTH(GROUP_DEPTH)
    ) u_buf (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    dupm_emit #(
        .GROUP_DEPTH(GROUP_DEPTH),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush_ctrl (flush_ctrl),
        .flush_count(flush_count),
        .flush_best (flush_best),
        .flush_done (flush_done),
        .busy       (emit_busy),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_ready_not_replaying: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !emit_busy)
        else $error("input ready during replay");

    a_no_write_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_busy |-> !ram_we)
        else $error("buffer written during replay");

    a_done_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_done |-> emit_busy)
        else $error("replay done without a replay");

endmodule

`default_nettype wire

// ----- design/dupm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth come from parameters; no dependencies.
`default_nettype none

module dupm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/dupm_group.sv -----
// Group tracker: key compare, best-score tracking and buffer writes.
// Sequences flushes of the buffered group; depends on dupm_pkg.
`default_nettype none

module dupm_group #(
    parameter int GROUP_DEPTH = 32,
    parameter int CNT_W       = $clog2(GROUP_DEPTH + 1),
    parameter int IDX_W       = $clog2(GROUP_DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire dupm_pkg::read_t               s_read,
    output logic                               ram_we,
    output logic [IDX_W-1:0]                   ram_waddr,
    output logic [dupm_pkg::DUPM_RAM_W-1:0]    ram_wdata,
    output dupm_pkg::flush_ctrl_t              flush_ctrl,
    output logic [CNT_W-1:0]                   flush_count,
    output logic [IDX_W-1:0]                   flush_best,
    input  wire logic                          flush_done
);
    import dupm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_FLUSH_PRE  = 4'b0010,
        ST_ADD        = 4'b0100,
        ST_FLUSH_LAST = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic                      frag_mode_reg;
    read_t                     hold_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [DUPM_POS_W-1:0]     key_first_reg, key_first_next;
    logic [DUPM_POS_W-1:0]     key_second_reg, key_second_next;
    logic [DUPM_ORI_W-1:0]     key_ori_reg, key_ori_next;
    logic                      key_sec_reg, key_sec_next;
    logic [IDX_W-1:0]          best_reg, best_next;
    logic [DUPM_SCORE_W-1:0]   best_score_reg, best_score_next;
    logic                      seen_pair_reg, seen_pair_next;
    logic                      seen_frag_reg, seen_frag_next;
    logic                      split_reg, split_next;

    read_t                     src;
    logic                      accept;
    logic                      same;
    logic                      flush_need;
    logic                      apply_en;
    logic                      pre_start;
    logic                      last_start;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        src = (state_reg == ST_ADD) ? hold_reg : s_read;
        same = (s_read.end_first == key_first_reg) && (s_read.orientation == key_ori_reg) &&
               (frag_mode_reg || ((s_read.end_second == key_second_reg) &&
                                  (s_read.is_secondary == key_sec_reg)));
        flush_need = (count_reg != '0) && (!same || (count_reg >= CNT_W'(GROUP_DEPTH)));
        apply_en   = (accept && !flush_need) || (state_reg == ST_ADD);
        pre_start  = accept && flush_need;
        last_start = apply_en && src.last_read;

        count_next      = count_reg;
        key_first_next  = key_first_reg;
        key_second_next = key_second_reg;
        key_ori_next    = key_ori_reg;
        key_sec_next    = key_sec_reg;
        best_next       = best_reg;
        best_score_next = best_score_reg;
        seen_pair_next  = seen_pair_reg;
        seen_frag_next  = seen_frag_reg;

        if (apply_en) begin
            if (count_reg == '0) begin
                key_first_next  = src.end_first;
                key_second_next = src.end_second;
                key_ori_next    = src.orientation;
                key_sec_next    = src.is_secondary;
                best_next       = '0;
                best_score_next = src.score;
            end else if ($signed(src.score) > $signed(best_score_reg)) begin
                best_next       = count_reg[IDX_W-1:0];
                best_score_next = src.score;
            end
            count_next = count_reg + CNT_W'(1);
            if (src.is_paired) begin
                seen_pair_next = 1'b1;
            end else begin
                seen_frag_next = 1'b1;
            end
        end

        ram_we    = apply_en;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = {src.is_paired, src.tag};

        flush_ctrl.start = pre_start || last_start;
        flush_ctrl.last  = last_start;
        flush_ctrl.split = (pre_start && same) ? 1'b1 : split_reg;
        if (frag_mode_reg) begin
            if (seen_frag_next) begin
                flush_ctrl.mode = seen_pair_next ? MARK_UNPAIRED : MARK_ALL_BUT_BEST;
            end else begin
                flush_ctrl.mode = MARK_NONE;
            end
        end else if ((count_next > CNT_W'(1)) && !key_second_next[DUPM_POS_W-1]) begin
            flush_ctrl.mode = MARK_ALL_BUT_BEST;
        end else begin
            flush_ctrl.mode = MARK_NONE;
        end
        flush_count = count_next;
        flush_best  = best_next;

        split_next = split_reg;
        if (pre_start) begin
            split_next = same;
        end else if (last_start) begin
            split_next = 1'b0;
        end

        if (flush_ctrl.start) begin
            count_next      = '0;
            best_next       = '0;
            best_score_next = '0;
            seen_pair_next  = 1'b0;
            seen_frag_next  = 1'b0;
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pre_start) begin
                    state_next = ST_FLUSH_PRE;
                end else if (last_start) begin
                    state_next = ST_FLUSH_LAST;
                end
            end
            ST_FLUSH_PRE: begin
                if (flush_done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                state_next = last_start ? ST_FLUSH_LAST : ST_IDLE;
            end
            ST_FLUSH_LAST: begin
                if (flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frag_mode_reg  <= 1'b0;
            count_reg      <= '0;
            key_first_reg  <= '0;
            key_second_reg <= '0;
            key_ori_reg    <= '0;
            key_sec_reg    <= 1'b0;
            best_reg       <= '0;
            best_score_reg <= '0;
            seen_pair_reg  <= 1'b0;
            seen_frag_reg  <= 1'b0;
            split_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_we) begin
                frag_mode_reg <= cfg_wdata;
            end
            count_reg      <= count_next;
            key_first_reg  <= key_first_next;
            key_second_reg <= key_second_next;
            key_ori_reg    <= key_ori_next;
            key_sec_reg    <= key_sec_next;
            best_reg       <= best_next;
            best_score_reg <= best_score_next;
            seen_pair_reg  <= seen_pair_next;
            seen_frag_reg  <= seen_frag_next;
            split_reg      <= split_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= s_read;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(GROUP_DEPTH))
        else $error("group count above buffer depth");

    a_pre_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH_PRE) |-> (count_reg == '0))
        else $error("buffer not emptied before replay");

    a_add_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |-> ($past(state_reg) == ST_FLUSH_PRE) && $past(flush_done))
        else $error("held read written without a finished flush");

endmodule

`default_nettype wire

// ----- design/dupm_emit.sv -----
// Group replay: reads the buffered group from the RAM and drives the result stream.
// Applies the duplicate mark per read; depends on dupm_pkg.
`default_nettype none

module dupm_emit #(
    parameter int GROUP_DEPTH = 32,
    parameter int CNT_W       = $clog2(GROUP_DEPTH + 1),
    parameter int IDX_W       = $clog2(GROUP_DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dupm_pkg::flush_ctrl_t         flush_ctrl,
    input  wire logic [CNT_W-1:0]              flush_count,
    input  wire logic [IDX_W-1:0]              flush_best,
    output logic                               flush_done,
    output logic                               busy,
    output logic [IDX_W-1:0]                   ram_raddr,
    input  wire logic [dupm_pkg::DUPM_RAM_W-1:0] ram_rdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dupm_pkg::DUPM_TAG_W-1:0]    m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import dupm_pkg::*;

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      best_reg;
    mark_mode_t            mode_reg;
    logic                  split_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      issue_reg;
    logic                  inflight_reg;
    logic [IDX_W-1:0]      data_idx_reg;
    logic                  m_valid_reg;
    logic [DUPM_TAG_W-1:0] tag_reg;
    logic                  dup_reg;
    logic                  osplit_reg;
    logic                  olast_reg;

    logic                  issue;
    logic                  final_rd;
    logic                  dup;

    assign issue     = busy_reg && !inflight_reg && (issue_reg < cnt_reg) &&
                       (!m_valid_reg || m_tready);
    assign ram_raddr = issue_reg[IDX_W-1:0];
    assign final_rd  = inflight_reg && ((CNT_W'(data_idx_reg) + CNT_W'(1)) == cnt_reg);
    assign flush_done = final_rd;
    assign busy       = busy_reg;

    always_comb begin
        case (mode_reg)
            MARK_ALL_BUT_BEST: dup = (data_idx_reg != best_reg);
            MARK_UNPAIRED:     dup = !ram_rdata[DUPM_RAM_W-1];
            default:           dup = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            issue_reg    <= '0;
        end else begin
            if (flush_ctrl.start) begin
                busy_reg  <= 1'b1;
                issue_reg <= '0;
            end else if (issue) begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (final_rd) begin
                busy_reg <= 1'b0;
            end
            inflight_reg <= issue;
            if (inflight_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (flush_ctrl.start) begin
            cnt_reg   <= flush_count;
            best_reg  <= flush_best;
            mode_reg  <= flush_ctrl.mode;
            split_reg <= flush_ctrl.split;
            last_reg  <= flush_ctrl.last;
        end
        if (issue) begin
            data_idx_reg <= issue_reg[IDX_W-1:0];
        end
        if (inflight_reg) begin
            tag_reg    <= ram_rdata[DUPM_TAG_W-1:0];
            dup_reg    <= dup;
            osplit_reg <= split_reg;
            olast_reg  <= last_reg && final_rd;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tag_reg;
    assign m_tuser  = {osplit_reg, dup_reg};
    assign m_tlast  = olast_reg;

    a_load_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(inflight_reg))
        else $error("result shown without a buffer read");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_ctrl.start |-> !busy_reg)
        else $error("flush started while a replay runs");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        final_rd |=> !busy_reg && !inflight_reg)
        else $error("replay still active after its final read");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for duplicate_read_marker: streams sorted reads in,
// predicts each group's duplicate marks and compares every result transaction.
// Depends on dupm_pkg and the duplicate_read_marker RTL.
`timescale 1ns / 100ps

module tb_top;

    import dupm_pkg::*;

    localparam int GROUP_DEPTH   = DUPM_GROUP_DEPTH;
    localparam int SETTLE_CYCLES = 2 * GROUP_DEPTH + 16;

    typedef struct {
        logic [31:0] tag;
        logic        dup;
        logic        split;
        logic        last;
    } mark_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    duplicate_read_marker #(
        .GROUP_DEPTH (GROUP_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    mark_t marks_due[$];
    int    mismatches = 0;
    bit    gaps_on    = 1'b1;
    bit    stalls_on  = 1'b1;
    int    sink_hold  = 0;

    // Group tracking state
    bit                 frag_mode     = 1'b0;
    logic [31:0]        grp_tag[GROUP_DEPTH];
    logic               grp_paired[GROUP_DEPTH];
    int                 grp_count     = 0;
    logic signed [31:0] key_first     = '0;
    logic signed [31:0] key_second    = '0;
    logic [1:0]         key_ori       = '0;
    logic               key_sec       = 1'b0;
    int                 best_idx      = 0;
    logic signed [31:0] best_score    = '0;
    bit                 seen_pair     = 1'b0;
    bit                 seen_frag     = 1'b0;
    bit                 split_pending = 1'b0;

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(4, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void close_group(input bit split);
        mark_mode_t how;
        mark_t      m;
        int         i;
        how = MARK_NONE;
        if (frag_mode) begin
            if (seen_frag)
                how = seen_pair ? MARK_UNPAIRED : MARK_ALL_BUT_BEST;
        end else if (grp_count > 1 && !key_second[31]) begin
            how = MARK_ALL_BUT_BEST;
        end
        for (i = 0; i < grp_count; i++) begin
            m.tag   = grp_tag[i];
            m.split = split;
            m.last  = 1'b0;
            case (how)
                MARK_ALL_BUT_BEST: m.dup = (i != best_idx);
                MARK_UNPAIRED:     m.dup = !grp_paired[i];
                default:           m.dup = 1'b0;
            endcase
            marks_due.push_back(m);
        end
        grp_count  = 0;
        best_idx   = 0;
        best_score = '0;
        seen_pair  = 1'b0;
        seen_frag  = 1'b0;
    endfunction

    function automatic void mark_duplicates(input read_t r);
        bit    same;
        mark_t m;
        if (grp_count > 0) begin
            same = r.end_first == key_first && r.orientation == key_ori &&
                   (frag_mode || (r.end_second == key_second &&
                                  r.is_secondary == key_sec));
            if (!same) begin
                close_group(split_pending);
                split_pending = 1'b0;
            end else if (grp_count >= GROUP_DEPTH) begin
                close_group(1'b1);
                split_pending = 1'b1;
            end
        end
        if (grp_count == 0) begin
            key_first  = r.end_first;
            key_second = r.end_second;
            key_ori    = r.orientation;
            key_sec    = r.is_secondary;
            best_idx   = 0;
            best_score = r.score;
        end else if (r.score > best_score) begin
            best_idx   = grp_count;
            best_score = r.score;
        end
        grp_tag[grp_count]    = r.tag;
        grp_paired[grp_count] = r.is_paired;
        grp_count++;
        if (r.is_paired)
            seen_pair = 1'b1;
        else
            seen_frag = 1'b1;
        if (r.last_read) begin
            close_group(split_pending);
            split_pending = 1'b0;
            m = marks_due.pop_back();
            m.last = 1'b1;
            marks_due.push_back(m);
        end
    endfunction

    function automatic read_t make_read(input logic [31:0] tag, input logic [31:0] ef,
                                        input logic [31:0] es, input logic [1:0] ori,
                                        input logic sec, input logic pr,
                                        input logic [31:0] sc, input logic last);
        read_t r;
        r.tag          = tag;
        r.end_first    = ef;
        r.end_second   = es;
        r.orientation  = ori;
        r.is_secondary = sec;
        r.is_paired    = pr;
        r.score        = sc;
        r.last_read    = last;
        return r;
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 20) - 10;
            2:       return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic read_t random_read(input logic last);
        return make_read($urandom, $urandom, $urandom, $urandom_range(0, 3),
                         $urandom_range(0, 1), $urandom_range(0, 1), $urandom, last);
    endfunction

    task automatic send_read(input read_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.score, r.orientation, r.end_second, r.end_first, r.tag};
        s_tuser  <= {r.is_paired, r.is_secondary};
        s_tlast  <= r.last_read;
        do @(posedge aclk); while (!s_tready);
        mark_duplicates(r);
        gap = (gaps_on && $urandom_range(0, 4) < 2) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_marks();
        s_tvalid <= 1'b0;
        while (marks_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input bit mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        frag_mode = mode;
    endtask

    task automatic test_pair_marking();
        send_read(make_read(32'h0, 32'h8000_0000, 32'h7fff_ffff, 2'd0, 1'b0, 1'b1,
                            32'h8000_0000, 1'b1));
        send_read(make_read(32'hffff_ffff, 100, 200, 2'd1, 1'b0, 1'b1, 5, 1'b0));
        send_read(make_read(32'h1, 100, 200, 2'd1, 1'b0, 1'b1, 9, 1'b0));
        send_read(make_read(32'h2, 100, 200, 2'd1, 1'b0, 1'b0, 9, 1'b0));
        send_read(make_read(32'h3, 100, 200, 2'd1, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0));
        send_read(make_read(32'h4, 100, 200, 2'd1, 1'b1, 1'b1, 32'h8000_0000, 1'b0));
        send_read(make_read(32'h5, 100, 32'hffff_ffff, 2'd3, 1'b1, 1'b1, 8, 1'b0));
        send_read(make_read(32'h6, 100, 32'hffff_ffff, 2'd3, 1'b1, 1'b1, 9, 1'b0));
        send_read(make_read(32'h7, 100, 200, 2'd2, 1'b0, 1'b1, 3, 1'b0));
        send_read(make_read(32'h8, 100, 200, 2'd2, 1'b0, 1'b0, 3, 1'b1));
        wait_for_marks();
    endtask

    task automatic test_mode_switch();
        send_read(make_read(32'h10, -5, 10, 2'd0, 1'b0, 1'b0, 1, 1'b1));
        wait_for_marks();
        set_mode(1'b1);
        send_read(make_read(32'h11, -5, 99, 2'd0, 1'b1, 1'b0, 2, 1'b0));
        send_read(make_read(32'h12, -5, 0, 2'd0, 1'b0, 1'b1, 0, 1'b1));
        wait_for_marks();
    endtask

    task automatic test_fragment_marking();
        send_read(make_read(32'h20, 7, 1, 2'd1, 1'b0, 1'b1, 4, 1'b0));
        send_read(make_read(32'h21, 7, 2, 2'd1, 1'b1, 1'b1, 5, 1'b0));
        send_read(make_read(32'h22, 7, 3, 2'd2, 1'b0, 1'b0, 1, 1'b0));
        send_read(make_read(32'h23, 7, 4, 2'd2, 1'b0, 1'b0, 4, 1'b0));
        send_read(make_read(32'h24, 7, 5, 2'd2, 1'b1, 1'b0, 2, 1'b0));
        send_read(make_read(32'h25, 8, -1, 2'd2, 1'b0, 1'b0, 6, 1'b0));
        send_read(make_read(32'h26, -9, 0, 2'd3, 1'b0, 1'b1, 1, 1'b0));
        send_read(make_read(32'h27, -9, 0, 2'd3, 1'b0, 1'b0, 7, 1'b0));
        send_read(make_read(32'h28, -9, 0, 2'd3, 1'b0, 1'b0, 2, 1'b1));
        wait_for_marks();
    endtask

    task automatic test_split_groups();
        read_t r;
        int    n;
        int    i;
        set_mode(1'b0);
        r = make_read(0, $urandom, $urandom_range(0, 1000), $urandom_range(0, 3),
                      $urandom_range(0, 1), 1'b1, 0, 1'b0);
        for (i = 0; i < GROUP_DEPTH + 1; i++) begin
            r.tag       = $urandom;
            r.is_paired = $urandom_range(0, 1);
            r.score     = $urandom_range(0, 7);
            r.last_read = (i == GROUP_DEPTH);
            send_read(r);
        end
        wait_for_marks();
        set_mode(1'b1);
        n = $urandom_range(GROUP_DEPTH + 1, GROUP_DEPTH + 8);
        r.end_first   = $urandom;
        r.orientation = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            r.tag          = $urandom;
            r.end_second   = $urandom;
            r.is_secondary = $urandom_range(0, 1);
            r.is_paired    = ($urandom_range(0, 3) == 0);
            r.score        = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
            r.last_read    = 1'b0;
            send_read(r);
        end
        r.tag       = $urandom;
        r.end_first = r.end_first ^ 32'h1;
        r.last_read = 1'b1;
        send_read(r);
        wait_for_marks();
    endtask

    task automatic run_random_groups(input int n_reads);
        read_t r;
        int    sent;
        int    grp_len;
        int    style;
        int    i;
        sent = 0;
        while (sent < n_reads) begin
            if ($urandom_range(0, 9) == 0) begin
                send_read(random_read($urandom_range(0, 29) == 0));
                sent++;
            end else begin
                grp_len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20)
                                                        : $urandom_range(1, 5);
                style = $urandom_range(0, 2);
                r = make_read(0, pick_pos(), pick_pos(), $urandom_range(0, 3),
                              $urandom_range(0, 7) == 0, 1'b0, 0, 1'b0);
                for (i = 0; i < grp_len; i++) begin
                    r.tag = $urandom;
                    if (frag_mode) begin
                        r.end_second   = $urandom;
                        r.is_secondary = $urandom_range(0, 1);
                    end
                    r.score     = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
                    r.is_paired = (style == 2) ? $urandom_range(0, 1) : style;
                    r.last_read = ($urandom_range(0, 29) == 0);
                    send_read(r);
                    sent++;
                end
            end
        end
        send_read(random_read(1'b1));
    endtask

    task automatic test_random_reads();
        set_mode(1'b0);
        run_random_groups(30);
        wait_for_marks();
        run_random_groups(30);
        wait_for_marks();
        set_mode(1'b1);
        run_random_groups(30);
        wait_for_marks();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_groups(25);
        wait_for_marks();
    endtask

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            m_tready  <= 1'b0;
            sink_hold = idle_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_marks
        mark_t m;
        if (aresetn && m_tvalid && m_tready) begin
            if (marks_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tag %h", $time,
                         m_tdata);
                mismatches++;
            end else begin
                m = marks_due.pop_front();
                if (m_tdata !== m.tag) begin
                    $display("%0t: out_tag expected %h actual %h", $time, m.tag, m_tdata);
                    mismatches++;
                end
                if (m_tuser[0] !== m.dup) begin
                    $display("%0t: duplicate of tag %h expected %b actual %b", $time,
                             m.tag, m.dup, m_tuser[0]);
                    mismatches++;
                end
                if (m_tuser[1] !== m.split) begin
                    $display("%0t: group_split of tag %h expected %b actual %b", $time,
                             m.tag, m.split, m_tuser[1]);
                    mismatches++;
                end
                if (m_tlast !== m.last) begin
                    $display("%0t: last_result of tag %h expected %b actual %b", $time,
                             m.tag, m.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_pair_marking();
        test_mode_switch();
        test_fragment_marking();
        test_split_groups();
        test_random_reads();
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/dupm_pkg.sv
design/dupm_ram.sv
design/dupm_group.sv
design/dupm_emit.sv
design/duplicate_read_marker.sv
tb/tb_top.sv
